[sv/lags_pkg.sv]
`default_nettype none

package lags_pkg;

	// fixed point format of every real value
	localparam int VW = 48;
	localparam int FB = 32;
	// full product and widest division numerator
	localparam int PW = 2 * VW;
	localparam int NW = VW + FB;

	typedef logic signed [VW-1:0] val_t;

	localparam val_t VMAX = {1'b0, {(VW-1){1'b1}}};
	localparam val_t VMIN = {1'b1, {(VW-1){1'b0}}};
	localparam val_t ONE = val_t'(64'd1 << FB);
	// relative tolerance of the specific leaf area fit, 1e-5 rounded
	localparam val_t FIT_LIMIT = val_t'(((64'd1 << FB) + 64'd50000) / 64'd100000);

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_RGR_MAX         = 3'd0,
		REG_RGR_MIN         = 3'd1,
		REG_SHOCK_FACTOR    = 3'd2,
		REG_HILLS_PER_AREA  = 3'd3,
		REG_PLANTS_PER_HILL = 3'd4,
		REG_SEEDBED_DENSITY = 3'd5,
		REG_EST_MODE        = 3'd6
	} reg_idx_t;

	typedef enum logic {
		OP_MUL = 1'b0,
		OP_DIV = 1'b1
	} alu_op_t;

	// saturating add
	function automatic val_t sat_add(input val_t a, input val_t b);
		logic signed [VW:0] s;
		s = {a[VW-1], a} + {b[VW-1], b};
		if (s[VW] != s[VW-1])
			return s[VW] ? VMIN : VMAX;
		return s[VW-1:0];
	endfunction

	// saturating subtract
	function automatic val_t sat_sub(input val_t a, input val_t b);
		logic signed [VW:0] s;
		s = {a[VW-1], a} - {b[VW-1], b};
		if (s[VW] != s[VW-1])
			return s[VW] ? VMIN : VMAX;
		return s[VW-1:0];
	endfunction

	// magnitude, the most negative value maps to 2^(VW-1)
	function automatic logic [VW-1:0] mag(input val_t a);
		return a[VW-1] ? (~a + 1'b1) : a;
	endfunction

	// apply sign to a wide magnitude and saturate
	function automatic val_t sat_mag(input logic neg, input logic [PW:0] m);
		logic [PW:0] lim;
		logic [VW-1:0] lo;
		lim = {{(PW+1-VW){1'b0}}, VMAX} + {{PW{1'b0}}, neg};
		lo = m[VW-1:0];
		if (m > lim)
			return neg ? VMIN : VMAX;
		return neg ? val_t'(~lo + 1'b1) : val_t'(lo);
	endfunction

endpackage

`default_nettype wire

[sv/leaf_area_growth_step_top.sv]
`default_nettype none

// Daily leaf area index growth. One transaction on s_* carries a day's inputs and
// gives one transaction on m_* with the leaf area index growth, the relative leaf
// growth rate and, in m_tuser, a flag that is low when no growth applies to the
// stage. Every multiply and divide runs through one shared unit: a multiply is a
// 48-bit shift-add and a divide an 80-bit restoring division, and each step of the
// sequencer issues one operation and waits for its result. s_tready is high only
// while the sequencer is idle; a finished result waits in the output register and
// does not hold off the next input, but a result that finds the output register
// still full waits for m_tready. Configuration is written through
// cfg_wen/cfg_index/cfg_data; the user must do so only while idle, as the block
// itself does not enforce it.
module leaf_area_growth_step_top (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// crop_stage[2:0], temp_sum[50:3], daily_temp[98:51], leaf_stress[131:99],
	// nitrogen_stress[164:132], dev_stage[211:165], leaf_area_index[258:212],
	// specific_leaf_area[305:259], leaf_growth_rate[353:306],
	// leaf_death_rate[400:354], green_leaf_weight[447:401]
	input  wire logic [447:0] s_tdata,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// lai_growth[47:0], rel_growth_rate[95:48]
	output logic [95:0]       m_tdata,
	// rate_valid[0]
	output logic              m_tuser,
	input  wire logic         cfg_wen,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [46:0]  cfg_data
);

	localparam int VW = lags_pkg::VW;
	localparam int FB = lags_pkg::FB;
	localparam int PW = lags_pkg::PW;
	localparam int NW = lags_pkg::NW;
	localparam int CW = $clog2(NW);
	localparam logic [PW:0] HALF = (PW+1)'(1) << (FB - 1);

	typedef enum logic [4:0] {
		ST_IDLE, ST_RGR, ST_EXP1, ST_EXP2, ST_EXP3,
		ST_TP1, ST_TP2, ST_TP3, ST_TP4,
		ST_FIT_R, ST_FIT_Q, ST_FIT_G2, ST_FIT_G1, ST_FIT_BM, ST_FIT_BD,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		KIND_SEED, KIND_FIELD, KIND_DIRECT
	} kind_t;

	// configuration
	logic [46:0] rgr_max_q, rgr_min_q, shock_factor_q, hills_q, pph_q, seed_dens_q;
	logic        mode_q;

	// latched item
	logic [2:0]      stage_q;
	lags_pkg::val_t  tsum_q, htemp_q, lstress_q, nstress_q, dvs_q, lai_q, sla_q;
	lags_pkg::val_t  rw_q, dldr_q, w_q;

	// persistent state
	logic [31:0]     blend_q;
	logic            locked_q;
	lags_pkg::val_t  sss_q, sd_q, sref_w_q, sref_l_q, fref_w_q, fref_l_q;

	// working registers
	state_t          state_q;
	kind_t           kind_q;
	logic            issued_q;
	lags_pkg::val_t  rgrl_q, glai_q, t_q, g2_q, wt_q, refw_q, refl_q;
	logic            valid_q;
	lags_pkg::val_t  out_glai_q, out_rgrl_q;
	logic            out_valid_q, m_tvalid_q;

	// shared unit
	logic              u_start, u_sh, u_done;
	lags_pkg::alu_op_t u_op;
	lags_pkg::val_t    u_a, u_b, u_res;
	logic              u_busy_q, u_fin_q, u_sh_q, u_neg_q, u_dz_q, u_apos_q, u_aneg_q;
	lags_pkg::alu_op_t u_op_q;
	logic [CW-1:0]     u_cnt_q;
	logic [PW-1:0]     prod_q, mcand_q;
	logic [VW-1:0]     mplier_q, dvsr_q;
	logic [NW-1:0]     num_q;
	logic [VW:0]       rem_q;

	// values decoded from the item and configuration
	lags_pkg::val_t mx, mn, wt_seed, wt_field, dq, dabs, w_div, cnt_ext, cnt_inc;
	logic           arith_st, lai_small, dvs_small;

	assign mx = lags_pkg::val_t'({1'b0, rgr_max_q});
	assign mn = lags_pkg::val_t'({1'b0, rgr_min_q});
	assign wt_seed = lags_pkg::sat_add(w_q, rw_q);
	assign wt_field = lags_pkg::sat_sub(wt_seed, dldr_q);
	assign dq = lags_pkg::sat_sub(t_q, sla_q);
	assign dabs = dq[VW-1] ? lags_pkg::sat_sub('0, dq) : dq;
	assign w_div = (w_q == '0) ? lags_pkg::ONE : w_q;
	assign cnt_ext = lags_pkg::val_t'({16'd0, blend_q});
	assign cnt_inc = lags_pkg::val_t'({15'd0, {1'b0, blend_q} + 33'd1});
	assign lai_small = lai_q < lags_pkg::ONE;
	assign dvs_small = dvs_q < lags_pkg::ONE;

	assign arith_st = !(state_q == ST_IDLE || state_q == ST_OUT);
	assign u_start = arith_st && !issued_q;

	// operand selection per sequencer step
	always_comb begin
		u_op = lags_pkg::OP_MUL;
		u_sh = 1'b1;
		u_a = '0;
		u_b = '0;
		case (state_q)
			ST_RGR: begin
				u_a = lags_pkg::sat_sub(lags_pkg::ONE, nstress_q);
				u_b = lags_pkg::sat_sub(mx, mn);
			end
			ST_EXP1: begin
				u_a = (kind_q == KIND_FIELD) ? lstress_q : lai_q;
				u_b = (kind_q == KIND_FIELD) ? lai_q : rgrl_q;
			end
			ST_EXP2: begin
				u_a = t_q;
				u_b = (kind_q == KIND_FIELD) ? rgrl_q : htemp_q;
			end
			ST_EXP3: begin
				u_a = t_q;
				u_b = (kind_q == KIND_FIELD) ? htemp_q : lstress_q;
			end
			ST_TP1: begin
				u_a = lags_pkg::val_t'({1'b0, shock_factor_q});
				u_b = tsum_q;
			end
			ST_TP2: begin
				u_a = lai_q;
				u_b = lags_pkg::val_t'({1'b0, hills_q});
			end
			ST_TP3: begin
				u_a = t_q;
				u_b = lags_pkg::val_t'({1'b0, pph_q});
			end
			ST_TP4: begin
				u_op = lags_pkg::OP_DIV;
				u_a = t_q;
				u_b = lags_pkg::val_t'({1'b0, seed_dens_q});
			end
			ST_FIT_R: begin
				u_op = lags_pkg::OP_DIV;
				u_a = lai_q;
				u_b = w_div;
			end
			ST_FIT_Q: begin
				u_op = lags_pkg::OP_DIV;
				u_a = dabs;
				u_b = sla_q;
			end
			ST_FIT_G2: begin
				u_a = wt_q;
				u_b = sla_q;
			end
			ST_FIT_G1: begin
				u_a = lags_pkg::sat_sub(wt_q, refw_q);
				u_b = sla_q;
			end
			ST_FIT_BM: begin
				u_sh = 1'b0;
				u_a = g2_q;
				u_b = cnt_ext;
			end
			ST_FIT_BD: begin
				u_op = lags_pkg::OP_DIV;
				u_sh = 1'b0;
				u_a = t_q;
				u_b = cnt_inc;
			end
			default: begin
				u_op = lags_pkg::OP_MUL;
			end
		endcase
	end

	// shared shift-add multiplier and restoring divider
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			u_busy_q <= 1'b0;
			u_fin_q <= 1'b0;
		end else begin
			u_fin_q <= 1'b0;
			if (u_start) begin
				u_busy_q <= 1'b1;
				u_cnt_q <= '0;
				u_op_q <= u_op;
				u_sh_q <= u_sh;
				u_neg_q <= u_a[VW-1] != u_b[VW-1];
				u_dz_q <= u_b == '0;
				u_apos_q <= !u_a[VW-1] && (u_a != '0);
				u_aneg_q <= u_a[VW-1];
				prod_q <= '0;
				mcand_q <= PW'(lags_pkg::mag(u_b));
				mplier_q <= lags_pkg::mag(u_a);
				num_q <= u_sh ? {lags_pkg::mag(u_a), {FB{1'b0}}} : NW'(lags_pkg::mag(u_a));
				rem_q <= '0;
				dvsr_q <= lags_pkg::mag(u_b);
			end else if (u_busy_q) begin
				u_cnt_q <= u_cnt_q + 1'b1;
				if (u_op_q == lags_pkg::OP_MUL) begin
					if (mplier_q[0])
						prod_q <= prod_q + mcand_q;
					mcand_q <= mcand_q << 1;
					mplier_q <= mplier_q >> 1;
					if (u_cnt_q == CW'(VW - 1)) begin
						u_busy_q <= 1'b0;
						u_fin_q <= 1'b1;
					end
				end else begin
					if ({rem_q[VW-1:0], num_q[NW-1]} >= {1'b0, dvsr_q}) begin
						rem_q <= {rem_q[VW-1:0], num_q[NW-1]} - {1'b0, dvsr_q};
						num_q <= {num_q[NW-2:0], 1'b1};
					end else begin
						rem_q <= {rem_q[VW-1:0], num_q[NW-1]};
						num_q <= {num_q[NW-2:0], 1'b0};
					end
					if (u_cnt_q == CW'(NW - 1)) begin
						u_busy_q <= 1'b0;
						u_fin_q <= 1'b1;
					end
				end
			end
		end
	end

	// rounding and saturation of the unit result
	logic [PW:0] rnd, mul_m, div_m;
	always_comb begin
		rnd = {1'b0, prod_q} + (u_sh_q ? HALF : '0);
		mul_m = u_sh_q ? (rnd >> FB) : rnd;
		div_m = (PW+1)'({1'b0, num_q}) +
			(PW+1)'({rem_q, 1'b0} >= {2'b0, dvsr_q});
		if (u_op_q == lags_pkg::OP_MUL)
			u_res = lags_pkg::sat_mag(u_neg_q, mul_m);
		else if (u_dz_q)
			u_res = u_aneg_q ? lags_pkg::VMIN : (u_apos_q ? lags_pkg::VMAX : '0);
		else
			u_res = lags_pkg::sat_mag(u_neg_q, div_m);
	end
	assign u_done = u_fin_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rgr_max_q <= '0;
			rgr_min_q <= '0;
			shock_factor_q <= '0;
			hills_q <= '0;
			pph_q <= '0;
			seed_dens_q <= 47'd4294967296;
			mode_q <= 1'b0;
		end else if (cfg_wen) begin
			case (cfg_index)
				lags_pkg::REG_RGR_MAX:         rgr_max_q <= cfg_data;
				lags_pkg::REG_RGR_MIN:         rgr_min_q <= cfg_data;
				lags_pkg::REG_SHOCK_FACTOR:    shock_factor_q <= cfg_data;
				lags_pkg::REG_HILLS_PER_AREA:  hills_q <= cfg_data;
				lags_pkg::REG_PLANTS_PER_HILL: pph_q <= cfg_data;
				lags_pkg::REG_SEEDBED_DENSITY: seed_dens_q <= cfg_data;
				lags_pkg::REG_EST_MODE:        mode_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			issued_q <= 1'b0;
			blend_q <= 32'd1;
			locked_q <= 1'b0;
			sss_q <= '0;
			sd_q <= '0;
			sref_w_q <= '0;
			sref_l_q <= '0;
			fref_w_q <= '0;
			fref_l_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			// the output step reloads the output register itself
			if (m_tvalid_q && m_tready && state_q != ST_OUT)
				m_tvalid_q <= 1'b0;
			if (u_done)
				issued_q <= 1'b0;
			else if (u_start)
				issued_q <= 1'b1;
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						stage_q <= s_tdata[2:0];
						tsum_q <= s_tdata[50:3];
						htemp_q <= s_tdata[98:51];
						lstress_q <= lags_pkg::val_t'({15'd0, s_tdata[131:99]});
						nstress_q <= lags_pkg::val_t'({15'd0, s_tdata[164:132]});
						dvs_q <= lags_pkg::val_t'({1'b0, s_tdata[211:165]});
						lai_q <= lags_pkg::val_t'({1'b0, s_tdata[258:212]});
						sla_q <= lags_pkg::val_t'({1'b0, s_tdata[305:259]});
						rw_q <= s_tdata[353:306];
						dldr_q <= lags_pkg::val_t'({1'b0, s_tdata[400:354]});
						w_q <= lags_pkg::val_t'({1'b0, s_tdata[447:401]});
						glai_q <= '0;
						valid_q <= 1'b1;
						if (s_tdata[2:0] <= 3'd1) begin
							blend_q <= 32'd1;
							locked_q <= 1'b0;
						end
						state_q <= ST_RGR;
					end
				end
				ST_RGR: begin
					if (u_done) begin
						rgrl_q <= lags_pkg::sat_sub(mx, u_res);
						wt_q <= wt_field;
						refw_q <= fref_w_q;
						refl_q <= fref_l_q;
						if (mode_q) begin
							kind_q <= KIND_DIRECT;
							if (lai_small && dvs_small)
								state_q <= ST_EXP1;
							else
								state_q <= locked_q ? ST_FIT_G2 : ST_FIT_R;
						end else if (stage_q < 3'd3) begin
							kind_q <= KIND_SEED;
							wt_q <= wt_seed;
							refw_q <= sref_w_q;
							refl_q <= sref_l_q;
							if (lai_small)
								state_q <= ST_EXP1;
							else
								state_q <= locked_q ? ST_FIT_G2 : ST_FIT_R;
						end else if (stage_q == 3'd3) begin
							sss_q <= tsum_q;
							state_q <= ST_TP1;
						end else if (stage_q == 3'd4) begin
							kind_q <= KIND_FIELD;
							if (tsum_q < lags_pkg::sat_add(sss_q, sd_q))
								state_q <= ST_OUT;
							else if (lai_small && dvs_small)
								state_q <= ST_EXP1;
							else
								state_q <= locked_q ? ST_FIT_G2 : ST_FIT_R;
						end else begin
							valid_q <= 1'b0;
							state_q <= ST_OUT;
						end
					end
				end
				ST_EXP1: begin
					if (u_done) begin
						t_q <= u_res;
						state_q <= ST_EXP2;
					end
				end
				ST_EXP2: begin
					if (u_done) begin
						if (kind_q == KIND_SEED) begin
							glai_q <= u_res;
							sref_w_q <= w_q;
							sref_l_q <= lai_q;
							state_q <= ST_OUT;
						end else begin
							t_q <= u_res;
							state_q <= ST_EXP3;
						end
					end
				end
				ST_EXP3: begin
					if (u_done) begin
						glai_q <= u_res;
						fref_w_q <= w_q;
						fref_l_q <= lai_q;
						state_q <= ST_OUT;
					end
				end
				ST_TP1: begin
					if (u_done) begin
						sd_q <= u_res;
						state_q <= ST_TP2;
					end
				end
				ST_TP2: begin
					if (u_done) begin
						t_q <= u_res;
						state_q <= ST_TP3;
					end
				end
				ST_TP3: begin
					if (u_done) begin
						t_q <= u_res;
						state_q <= ST_TP4;
					end
				end
				ST_TP4: begin
					if (u_done) begin
						glai_q <= lags_pkg::sat_sub(u_res, lai_q);
						locked_q <= 1'b0;
						blend_q <= 32'd1;
						state_q <= ST_OUT;
					end
				end
				ST_FIT_R: begin
					if (u_done) begin
						t_q <= u_res;
						state_q <= ST_FIT_Q;
					end
				end
				ST_FIT_Q: begin
					if (u_done) begin
						if (u_res < lags_pkg::FIT_LIMIT)
							locked_q <= 1'b1;
						state_q <= ST_FIT_G2;
					end
				end
				ST_FIT_G2: begin
					if (u_done) begin
						g2_q <= lags_pkg::sat_sub(u_res, lai_q);
						if (locked_q) begin
							glai_q <= lags_pkg::sat_sub(u_res, lai_q);
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_FIT_G1;
						end
					end
				end
				ST_FIT_G1: begin
					if (u_done) begin
						t_q <= lags_pkg::sat_sub(lags_pkg::sat_add(u_res, refl_q), lai_q);
						state_q <= ST_FIT_BM;
					end
				end
				ST_FIT_BM: begin
					if (u_done) begin
						t_q <= lags_pkg::sat_add(t_q, u_res);
						state_q <= ST_FIT_BD;
					end
				end
				ST_FIT_BD: begin
					if (u_done) begin
						glai_q <= u_res;
						if (blend_q != '1)
							blend_q <= blend_q + 32'd1;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						out_glai_q <= glai_q;
						out_rgrl_q <= rgrl_q;
						out_valid_q <= valid_q;
						m_tvalid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_tready = state_q == ST_IDLE;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata = {out_rgrl_q, out_glai_q};
	assign m_tuser = out_valid_q;

	// the shared unit is never busy while a new item can enter
	assert property (@(posedge clk) disable iff (!arst_n) s_tready |-> !u_busy_q)
		else $error("shared unit busy while idle");

	// the blend counter never wraps to zero
	assert property (@(posedge clk) disable iff (!arst_n) blend_q != 32'd0)
		else $error("blend counter reached zero");

	// a unit result only appears for an operation the sequencer issued
	assert property (@(posedge clk) disable iff (!arst_n) u_done |-> issued_q && arith_st)
		else $error("unit result without a pending operation");

endmodule

`default_nettype wire

[bench/leaf_area_growth_step_top_test.sv]
`default_nettype none

module leaf_area_growth_step_top_test;

	localparam longint Q_ONE = 64'sd1 << 32;
	localparam longint Q_MAX = (64'sd1 << 47) - 1;
	localparam longint Q_MIN = -(64'sd1 << 47);
	localparam longint FIT_TOL = ((64'sd1 << 32) + 50000) / 100000;
	localparam int CYCLE_LIMIT = 3000000;

	typedef struct {
		logic [47:0] lai_growth;
		logic [47:0] rel_rate;
		logic        rate_valid;
	} growth_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [447:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [95:0] m_tdata;
	logic m_tuser;
	logic cfg_wen = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [46:0] cfg_data = '0;

	leaf_area_growth_step_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// shadow configuration and crop state
	longint rgr_hi, rgr_lo, shock_k, hills, plants, sb_density;
	bit direct_seed;
	bit [31:0] blend_cnt;
	bit fit_locked;
	longint shock_start, shock_dly, sb_ref_w, sb_ref_lai, fd_ref_w, fd_ref_lai;

	logic [447:0] pending_days[$];
	growth_t growth_q[$];
	bit held = 0;
	int cycles = 0;
	int fails = 0;

	always #5 clk = ~clk;

	function automatic longint q_clamp(longint v);
		if (v > Q_MAX) return Q_MAX;
		if (v < Q_MIN) return Q_MIN;
		return v;
	endfunction

	function automatic longint q_add(longint a, longint b);
		return q_clamp(a + b);
	endfunction

	function automatic longint q_sub(longint a, longint b);
		return q_clamp(a - b);
	endfunction

	function automatic logic [127:0] q_mag(longint a);
		return 128'(a < 0 ? -a : a);
	endfunction

	function automatic longint q_signed(bit neg, logic [127:0] m);
		logic [127:0] lim;
		lim = neg ? 128'(64'd1 << 47) : 128'(Q_MAX);
		if (m > lim) return neg ? Q_MIN : Q_MAX;
		return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
	endfunction

	// a * b / 2^sh, nearest, ties away from zero
	function automatic longint q_mul(longint a, longint b, int sh);
		logic [127:0] m;
		m = q_mag(a) * q_mag(b);
		if (sh > 0)
			m = (m + (128'd1 << (sh - 1))) >> sh;
		return q_signed((a < 0) != (b < 0), m);
	endfunction

	// a * 2^sh / b, nearest, saturating on a zero divisor
	function automatic longint q_div(longint a, longint b, int sh);
		logic [127:0] n, d, q, r;
		if (b == 0) return a > 0 ? Q_MAX : (a < 0 ? Q_MIN : 0);
		n = q_mag(a) << sh;
		d = q_mag(b);
		q = n / d;
		r = n - q * d;
		if (r >= d - r) q = q + 1;
		return q_signed((a < 0) != (b < 0), q);
	endfunction

	// blend toward sla growth, or sla growth once the fit locks
	function automatic longint sla_blend(longint wt, longint refw, longint refl,
			longint lai, longint w, longint sla);
		longint ratio, diff, g1, g2, acc, res;
		if (!fit_locked) begin
			ratio = q_div(lai, w == 0 ? Q_ONE : w, 32);
			diff = q_sub(ratio, sla);
			if (diff < 0) diff = q_sub(0, diff);
			if (q_div(diff, sla, 32) < FIT_TOL) fit_locked = 1;
		end
		g2 = q_sub(q_mul(wt, sla, 32), lai);
		if (fit_locked) return g2;
		g1 = q_sub(q_add(q_mul(q_sub(wt, refw), sla, 32), refl), lai);
		acc = q_add(g1, q_mul(g2, longint'({32'b0, blend_cnt}), 0));
		res = q_div(acc, longint'({32'b0, blend_cnt}) + 1, 0);
		if (blend_cnt != 32'hFFFF_FFFF) blend_cnt++;
		return res;
	endfunction

	function automatic growth_t daily_growth(logic [447:0] d);
		growth_t g;
		logic [2:0] stage;
		longint tsum, htemp, lstr, nstr, dvs, lai, sla, rw, dldr, w, rate, glai, t;
		stage = d[2:0];
		tsum = longint'($signed(d[50:3]));
		htemp = longint'($signed(d[98:51]));
		lstr = longint'(d[131:99]);
		nstr = longint'(d[164:132]);
		dvs = longint'(d[211:165]);
		lai = longint'(d[258:212]);
		sla = longint'(d[305:259]);
		rw = longint'($signed(d[353:306]));
		dldr = longint'(d[400:354]);
		w = longint'(d[447:401]);
		glai = 0;
		g.rate_valid = 1;
		if (stage <= 1) begin
			blend_cnt = 1;
			fit_locked = 0;
		end
		rate = q_sub(rgr_hi, q_mul(q_sub(Q_ONE, nstr), q_sub(rgr_hi, rgr_lo), 32));
		if (!direct_seed) begin
			if (stage < 3) begin
				if (lai < Q_ONE) begin
					glai = q_mul(q_mul(lai, rate, 32), htemp, 32);
					sb_ref_w = w;
					sb_ref_lai = lai;
				end else
					glai = sla_blend(q_add(w, rw), sb_ref_w, sb_ref_lai, lai, w, sla);
			end else if (stage == 3) begin
				shock_start = tsum;
				shock_dly = q_mul(shock_k, tsum, 32);
				t = q_mul(lai, hills, 32);
				t = q_mul(t, plants, 32);
				t = q_div(t, sb_density, 32);
				glai = q_sub(t, lai);
				fit_locked = 0;
				blend_cnt = 1;
			end else if (stage == 4) begin
				if (tsum < q_add(shock_start, shock_dly))
					glai = 0;
				else if (lai < Q_ONE && dvs < Q_ONE) begin
					glai = q_mul(q_mul(q_mul(lstr, lai, 32), rate, 32), htemp, 32);
					fd_ref_w = w;
					fd_ref_lai = lai;
				end else
					glai = sla_blend(q_sub(q_add(w, rw), dldr), fd_ref_w, fd_ref_lai,
						lai, w, sla);
			end else
				g.rate_valid = 0;
		end else begin
			if (lai < Q_ONE && dvs < Q_ONE) begin
				glai = q_mul(q_mul(q_mul(lai, rate, 32), htemp, 32), lstr, 32);
				fd_ref_w = w;
				fd_ref_lai = lai;
			end else
				glai = sla_blend(q_sub(q_add(w, rw), dldr), fd_ref_w, fd_ref_lai,
					lai, w, sla);
		end
		g.lai_growth = glai[47:0];
		g.rel_rate = rate[47:0];
		return g;
	endfunction

	// random raw field: extremes, small magnitudes or anything
	function automatic logic [63:0] rnd_field(int width, bit is_signed);
		logic [63:0] r, mask;
		mask = (64'd1 << width) - 1;
		case ($urandom_range(0, 9))
			0: r = 0;
			1: r = mask;
			2: r = 64'd1 << (width - 1);
			3: r = mask >> 1;
			4: r = 64'(Q_ONE);
			default: begin
				r = {$urandom, $urandom} & ((64'd1 << $urandom_range(8, width - 1)) - 1);
				if (is_signed && $urandom_range(0, 3) == 0) r = -r;
			end
		endcase
		return r & mask;
	endfunction

	function automatic logic [63:0] rnd_stress();
		case ($urandom_range(0, 5))
			0: return 0;
			1: return 64'(Q_ONE);
			default: return 64'($urandom);
		endcase
	endfunction

	function automatic logic [63:0] rnd_lai();
		case ($urandom_range(0, 4))
			0, 1: return 64'($urandom);
			2: return 64'(Q_ONE) + 64'($urandom_range(0, 255) * 64'(Q_ONE) / 16);
			default: return rnd_field(47, 0);
		endcase
	endfunction

	function automatic logic [447:0] pack_day(logic [2:0] stage, logic [47:0] tsum,
			logic [47:0] htemp, logic [32:0] ls, logic [32:0] ns, logic [46:0] dvs,
			logic [46:0] lai, logic [46:0] sla, logic [47:0] rw, logic [46:0] dldr,
			logic [46:0] w);
		if (sla == 0) sla = 1;
		return {w, dldr, rw, sla, lai, dvs, ns, ls, htemp, tsum, stage};
	endfunction

	function automatic logic [447:0] rnd_day(logic [2:0] stage);
		logic [46:0] w, sla, lai;
		w = rnd_field(47, 0);
		sla = rnd_field(47, 0);
		lai = rnd_lai();
		// about one day in six lies on the fit so the blend can lock
		if ($urandom_range(0, 5) == 0) begin
			w = 47'($urandom_range(1, 100)) << 32 | 47'($urandom);
			sla = 47'($urandom_range(1, 31)) << 32 | 47'($urandom);
			lai = 47'(q_mul(longint'(w), longint'(sla), 32));
		end
		return pack_day(stage, rnd_field(48, 1), rnd_field(48, 1), rnd_stress(),
			rnd_stress(), $urandom_range(0, 1) ? 47'($urandom) : rnd_field(47, 0),
			lai, sla, rnd_field(48, 1), rnd_field(47, 0), w);
	endfunction

	function automatic bit stall_now();
		if (cycles > 30000 && cycles < 60000) return 0;
		return $urandom_range(0, 99) < 16;
	endfunction

	// driver: present the oldest pending day
	always @(negedge clk) begin
		if (!held) begin
			if (arst_n && pending_days.size() > 0 && !stall_now()) begin
				s_tdata <= pending_days[0];
				s_tvalid <= 1'b1;
				held = 1;
			end else
				s_tvalid <= 1'b0;
		end
		m_tready <= !stall_now();
	end

	// accepted input transaction: predict its growth
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
		if (s_tvalid && s_tready) begin
			growth_q.push_back(daily_growth(pending_days.pop_front()));
			held = 0;
		end
	end

	// monitor: compare each output transaction with the oldest prediction
	always @(posedge clk) begin
		growth_t e;
		if (m_tvalid && m_tready) begin
			if (growth_q.size() == 0) begin
				$error("unexpected result %h", m_tdata);
				fails++;
			end else begin
				e = growth_q.pop_front();
				if (m_tdata[47:0] !== e.lai_growth) begin
					$error("lai_growth exp %h got %h", e.lai_growth, m_tdata[47:0]);
					fails++;
				end
				if (m_tdata[95:48] !== e.rel_rate) begin
					$error("rel_growth_rate exp %h got %h", e.rel_rate, m_tdata[95:48]);
					fails++;
				end
				if (m_tuser !== e.rate_valid) begin
					$error("rate_valid exp %b got %b", e.rate_valid, m_tuser);
					fails++;
				end
			end
		end
	end

	task automatic reg_write(lags_pkg::reg_idx_t idx, logic [46:0] value);
		@(negedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_wen <= 1'b0;
		case (idx)
			lags_pkg::REG_RGR_MAX: rgr_hi = longint'(value);
			lags_pkg::REG_RGR_MIN: rgr_lo = longint'(value);
			lags_pkg::REG_SHOCK_FACTOR: shock_k = longint'(value);
			lags_pkg::REG_HILLS_PER_AREA: hills = longint'(value);
			lags_pkg::REG_PLANTS_PER_HILL: plants = longint'(value);
			lags_pkg::REG_SEEDBED_DENSITY: sb_density = longint'(value);
			lags_pkg::REG_EST_MODE: direct_seed = value[0];
			default: ;
		endcase
	endtask

	task automatic drain();
		while (pending_days.size() > 0 || held || growth_q.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_all(logic [46:0] hi, logic [46:0] lo, logic [46:0] shk,
			logic [46:0] hl, logic [46:0] pl, logic [46:0] dens, bit mode);
		reg_write(lags_pkg::REG_RGR_MAX, hi);
		reg_write(lags_pkg::REG_RGR_MIN, lo);
		reg_write(lags_pkg::REG_SHOCK_FACTOR, shk);
		reg_write(lags_pkg::REG_HILLS_PER_AREA, hl);
		reg_write(lags_pkg::REG_PLANTS_PER_HILL, pl);
		reg_write(lags_pkg::REG_SEEDBED_DENSITY, dens == 0 ? 47'd1 : dens);
		reg_write(lags_pkg::REG_EST_MODE, 47'(mode));
	endtask

	// crop seasons: init, seedbed, transplant, field, with some noise days
	task automatic queue_seasons(int days);
		int n;
		n = 0;
		while (n < days) begin
			repeat ($urandom_range(1, 2)) pending_days.push_back(rnd_day(3'($urandom_range(0, 1))));
			repeat ($urandom_range(3, 8)) pending_days.push_back(rnd_day(3'd2));
			pending_days.push_back(rnd_day(3'd3));
			repeat ($urandom_range(8, 25)) begin
				if ($urandom_range(0, 9) == 0)
					pending_days.push_back(rnd_day(3'($urandom_range(0, 7))));
				else
					pending_days.push_back(rnd_day(3'd4));
			end
			n = n + pending_days.size();
			while (pending_days.size() > 0) @(posedge clk);
		end
	endtask

	initial begin
		logic [46:0] w, sla;
		rgr_hi = 0; rgr_lo = 0; shock_k = 0; hills = 0; plants = 0;
		sb_density = Q_ONE; direct_seed = 0;
		blend_cnt = 1; fit_locked = 0;
		shock_start = 0; shock_dly = 0;
		sb_ref_w = 0; sb_ref_lai = 0; fd_ref_w = 0; fd_ref_lai = 0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// directed days under typical settings
		write_all(47'(Q_ONE / 100), 47'(Q_ONE / 400), 47'(Q_ONE / 20), 47'(25 * Q_ONE),
			47'(3 * Q_ONE), 47'(1000 * Q_ONE), 0);
		for (int s = 0; s < 8; s++)
			pending_days.push_back(rnd_day(3'(s)));
		pending_days.push_back(pack_day(3'd2, '1, '1, 33'(Q_ONE), 33'(Q_ONE), '1, '1, '1,
			{1'b0, {47{1'b1}}}, '1, '1));
		pending_days.push_back(pack_day(3'd2, {1'b1, 47'b0}, {1'b1, 47'b0}, 0, 0, 0, 0, 1,
			{1'b1, 47'b0}, 0, 0));
		pending_days.push_back(pack_day(3'd0, 48'(Q_ONE), 48'(Q_ONE), 33'(Q_ONE), 0,
			0, 47'(Q_ONE / 2), 47'(Q_ONE), 0, 0, 47'(Q_ONE)));
		// zero leaf weight in the fit test
		pending_days.push_back(pack_day(3'd2, 0, 48'(Q_ONE), 0, 0, 0, 47'(2 * Q_ONE),
			47'(Q_ONE), 48'(Q_ONE), 0, 0));
		// exact fit locks the blend
		w = 47'(10 * Q_ONE);
		sla = 47'(Q_ONE / 4);
		pending_days.push_back(pack_day(3'd2, 0, 48'(Q_ONE), 0, 0, 0, 47'(q_mul(w, sla, 32)),
			sla, 48'(Q_ONE), 0, w));
		pending_days.push_back(pack_day(3'd2, 0, 48'(Q_ONE), 0, 0, 0, 47'(3 * Q_ONE),
			sla, 48'(Q_ONE), 0, w));
		pending_days.push_back(pack_day(3'd3, 48'(100 * Q_ONE), 0, 0, 0, 0,
			47'(3 * Q_ONE), sla, 0, 0, w));
		// still in transplant shock, then past it
		pending_days.push_back(pack_day(3'd4, 48'(101 * Q_ONE), 48'(Q_ONE), 33'(Q_ONE),
			33'(Q_ONE), 0, 47'(Q_ONE / 8), sla, 0, 0, w));
		pending_days.push_back(pack_day(3'd4, 48'(200 * Q_ONE), 48'(Q_ONE), 33'(Q_ONE),
			33'(Q_ONE), 0, 47'(Q_ONE / 8), sla, 0, 0, w));
		pending_days.push_back(pack_day(3'd4, 48'(200 * Q_ONE), 48'(Q_ONE), 0, 0,
			47'(2 * Q_ONE), 47'(4 * Q_ONE), sla, '1, '1, w));
		queue_seasons(60);
		drain();

		// extreme settings
		write_all('1, '1, '1, '1, '1, 47'd1, 0);
		queue_seasons(50);
		drain();
		write_all(0, '1, 0, 0, 0, '1, 0);
		queue_seasons(50);
		drain();

		// direct seeded crop
		write_all(47'(Q_ONE / 50), 47'(Q_ONE / 500), 47'(Q_ONE / 10), 47'(20 * Q_ONE),
			47'(2 * Q_ONE), 47'(500 * Q_ONE), 1);
		queue_seasons(60);
		drain();

		// random settings
		repeat (2) begin
			write_all(47'($urandom), 47'($urandom >> 4), rnd_field(47, 0), rnd_field(47, 0),
				rnd_field(47, 0), rnd_field(47, 0), $urandom_range(0, 1));
			queue_seasons(50);
			drain();
		end

		repeat (500) @(posedge clk);
		if (fails == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

`default_nettype wire
